FILE: rtl/core/pbd_pkg.sv
// pbd_pkg: shared widths, register indexes, reset values and the result word type
// for the push-button debounce core; no dependencies

package pbd_pkg;

    // field and register widths
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;
    localparam int unsigned RESULT_W   = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEGLITCH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;

    // register reset values
    localparam logic [PERIOD_W-1:0] DEGLITCH_RST   = 16'd10;
    localparam logic [PERIOD_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [PERIOD_W-1:0] LONG_PRESS_RST = 16'd1000;

    // pin level meaning released (active-low button)
    localparam logic LEVEL_RELEASED = 1'b1;

    // result word, changed in the lowest bit
    typedef struct packed {
        logic long_press;
        logic held;
        logic released;
        logic pressed;
        logic changed;
    } t_result;

endpackage

FILE: rtl/core/pbd_step.sv
// pbd_step: configuration registers, debounce state and the per-poll update logic
// depends on pbd_pkg

module pbd_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pbd_pkg::PERIOD_W-1:0]     i_cfg_data,
    input  logic                             i_fire,
    input  logic                             i_pin_level,
    input  logic [pbd_pkg::TIME_W-1:0]       i_now_ms,
    output pbd_pkg::t_result                 o_result
);
    import pbd_pkg::*;

    logic [PERIOD_W-1:0] r_deglitch;
    logic [PERIOD_W-1:0] r_debounce;
    logic [PERIOD_W-1:0] r_long_press;

    logic                r_prev;
    logic                r_accepted;
    logic                r_debounced;
    logic [TIME_W-1:0]   r_stable_since;
    logic [TIME_W-1:0]   r_last_change;
    logic [TIME_W-1:0]   r_last_press;
    logic                r_latched;
    logic                r_flag;

    logic                n_accepted;
    logic                n_debounced;
    logic [TIME_W-1:0]   n_stable_since;
    logic [TIME_W-1:0]   n_last_change;
    logic [TIME_W-1:0]   n_last_press;
    logic                n_latched;
    logic                n_flag;

    logic                stable;
    logic                accept;
    logic                chg;
    logic                held;
    logic                latch_mid;
    logic [TIME_W-1:0]   dt_stable;
    logic [TIME_W-1:0]   dt_change;
    logic [TIME_W-1:0]   dt_press;

    // elapsed times, modulo 2^32
    assign dt_stable = i_now_ms - r_stable_since;
    assign dt_change = i_now_ms - r_last_change;
    assign dt_press  = i_now_ms - r_last_press;

    // deglitch, debounce and long-press update for one poll
    always_comb begin
        stable         = (i_pin_level == r_prev);
        accept         = stable && (dt_stable > {{(TIME_W-PERIOD_W){1'b0}}, r_deglitch});
        n_accepted     = accept ? i_pin_level : r_accepted;
        n_stable_since = (!stable || accept) ? i_now_ms : r_stable_since;

        chg         = (n_accepted != r_debounced) &&
                      (dt_change > {{(TIME_W-PERIOD_W){1'b0}}, r_debounce});
        n_debounced = chg ? n_accepted : r_debounced;
        held        = !n_debounced;

        // release drops the latch, then the flag is re-evaluated while unlatched
        latch_mid = (chg && !held) ? 1'b0 : r_latched;
        if (!latch_mid) begin
            n_flag    = !chg && held &&
                        (dt_press > {{(TIME_W-PERIOD_W){1'b0}}, r_long_press});
            n_latched = n_flag;
        end else begin
            n_flag    = r_flag;
            n_latched = latch_mid;
        end

        n_last_change = chg ? i_now_ms : r_last_change;
        n_last_press  = (chg && held) ? i_now_ms : r_last_press;

        o_result.changed    = chg;
        o_result.pressed    = chg && held;
        o_result.released   = chg && !held;
        o_result.held       = held;
        o_result.long_press = n_flag;
    end

    // configuration registers, writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deglitch   <= DEGLITCH_RST;
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEGLITCH:   r_deglitch   <= i_cfg_data;
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // button state, advanced on each accepted poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev         <= LEVEL_RELEASED;
            r_accepted     <= LEVEL_RELEASED;
            r_debounced    <= LEVEL_RELEASED;
            r_stable_since <= '0;
            r_last_change  <= '0;
            r_last_press   <= '0;
            r_latched      <= 1'b0;
            r_flag         <= 1'b0;
        end else if (i_fire) begin
            r_prev         <= i_pin_level;
            r_accepted     <= n_accepted;
            r_debounced    <= n_debounced;
            r_stable_since <= n_stable_since;
            r_last_change  <= n_last_change;
            r_last_press   <= n_last_press;
            r_latched      <= n_latched;
            r_flag         <= n_flag;
        end
    end

endmodule

FILE: rtl/core/pbd_out_reg.sv
// pbd_out_reg: result register between the update logic and the master side
// depends on pbd_pkg

module pbd_out_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  pbd_pkg::t_result                 i_result,
    output logic                             o_space,
    output logic                             o_valid,
    input  logic                             i_ready,
    output pbd_pkg::t_result                 o_result
);
    import pbd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // a new word fits when the register is empty or being drained
    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/push_button_debounce_long_press_core.sv
// push_button_debounce_long_press_core: top level of the button debouncer
// depends on pbd_pkg, pbd_step, pbd_out_reg
//
//   channel   direction   handshake                      contents
//   s_axis    in          s_axis_tvalid / s_axis_tready  one poll: pin level, ms timestamp
//   m_axis    out         m_axis_tvalid / m_axis_tready  one result word per poll
//   cfg       in          i_cfg_we                       period registers, write only
//
// one poll per clock unless stalled; its word is registered and shows the next cycle
// the rate is set by the single state update path of three 32-bit compares
// a poll is still taken while the result register is drained in the same cycle
// a stalled master side holds the word and drops s_axis_tready
// synchronous active-low reset clears the state and loads the default periods

module push_button_debounce_long_press_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    input  logic [pbd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] changed, [1] pressed, [2] released, [3] held, [4] long_press, [7:5] zero
    output logic [pbd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pbd_pkg::PERIOD_W-1:0]      i_cfg_data
);
    import pbd_pkg::*;

    logic    fire;
    logic    space;
    t_result step_result;
    t_result out_result;

    assign s_axis_tready = space;
    assign fire          = s_axis_tvalid && space;

    // state update for one poll
    pbd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_pin_level (s_axis_tdata[0]),
        .i_now_ms    (s_axis_tdata[TIME_W:1]),
        .o_result    (step_result)
    );

    // result register
    pbd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (step_result),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, out_result};

endmodule

FILE: rtl/core/pbd_checker.sv
// pbd_checker: port-level assertions for the button debouncer, bound to the top level
// depends on pbd_pkg and push_button_debounce_long_press_core

module pbd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pbd_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import pbd_pkg::*;

    // nothing is offered in the cycle after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    // a press word is a change to the down level
    a_press_is_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[0] && m_axis_tdata[3]))
        else $error("press without change to held");

    // a release word is a change to the up level
    a_release_is_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[0] && !m_axis_tdata[3]))
        else $error("release without change to up");

    // long press only while held and never on a change word
    a_long_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[3] && !m_axis_tdata[0]))
        else $error("long press outside a steady hold");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind push_button_debounce_long_press_core pbd_checker u_pbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
